// ===== src/first_fit_heap_allocator_core_macros.svh =====
// Assertion macros used by the datapath of the first-fit heap allocator RTL.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_MACROS_SVH

// Checks prop in every cycle in which cond holds, outside reset.
`define FFHA_ASSERT_WHEN(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// Checks prop in every cycle outside reset.
`define FFHA_ASSERT_ALWAYS(lbl, prop, msg) `FFHA_ASSERT_WHEN(lbl, 1'b1, prop, msg)

`endif

// ===== src/ffha_pkg.sv =====
// Shared constants, codes and controller/datapath interface types of the allocator.
package ffha_pkg;

    localparam int unsigned ARENA_GRANULES = 4096;
    localparam int unsigned GRANULE_BYTES  = 16;
    localparam int unsigned GW             = $clog2(ARENA_GRANULES);
    localparam int unsigned SW             = GW + 1;
    localparam int unsigned OFS_SHIFT      = $clog2(GRANULE_BYTES);
    localparam int unsigned NEED_W         = 14;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_INIT  = 2'd2;

    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_ZERO_SIZE = 3'd1;
    localparam logic [2:0] STS_NO_ROOM   = 3'd2;
    localparam logic [2:0] STS_BAD_FREE  = 3'd3;
    localparam logic [2:0] STS_NULL_FREE = 3'd4;

    typedef enum logic [3:0] {
        ACT_NOP,
        ACT_ACCEPT,
        ACT_SWEEP,
        ACT_SEED,
        ACT_A_RD,
        ACT_A_CHK,
        ACT_A_WR2,
        ACT_F_RD,
        ACT_F_CHK,
        ACT_FW_RD,
        ACT_FW_CHK,
        ACT_FW_WR,
        ACT_BK_RD,
        ACT_BK_CHK,
        ACT_RESP
    } dp_act_t;

    typedef struct packed {
        dp_act_t act;
    } ffha_cmd_t;

    typedef struct packed {
        logic req_zero;
        logic free_reject;
        logic sweep_last;
        logic a_fit;
        logic a_split;
        logic a_last;
        logic f_in_use;
        logic f_last;
        logic fw_stop;
        logic g_zero;
        logic bk_end;
        logic out_free;
    } ffha_sts_t;

endpackage

// ===== src/ffha_datapath.sv =====
// Datapath of the allocator: header memory, walk registers, counters and result register.
`include "first_fit_heap_allocator_core_macros.svh"

module ffha_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [12:0]          cfg_arena_granules,
    input  logic [1:0]           s_opcode,
    input  logic [16:0]          s_request_bytes,
    input  logic [15:0]          s_free_offset,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_status,
    output logic [15:0]          m_payload_offset,
    output logic [16:0]          m_used_bytes,
    input  ffha_pkg::ffha_cmd_t  cmd,
    output ffha_pkg::ffha_sts_t  sts
);

    localparam int unsigned GW = ffha_pkg::GW;
    localparam int unsigned SW = ffha_pkg::SW;
    localparam int unsigned NW = ffha_pkg::NEED_W;

    // Each entry holds the in-use mark above the block size.
    logic [SW:0] mem [ffha_pkg::ARENA_GRANULES];
    logic [SW:0] rd_data_reg;
    logic [GW-1:0] rd_addr;
    logic          wr_en;
    logic [GW-1:0] wr_addr;
    logic [SW:0]   wr_data;

    logic [12:0]   cfg_reg, cfg_next;
    logic [SW-1:0] active_reg, active_next;
    logic [SW-1:0] used_reg, used_next;
    logic [GW-1:0] sweep_reg, sweep_next;
    logic [NW-1:0] need_reg, need_next;
    logic [GW-1:0] g_reg, g_next;
    logic [GW-1:0] p_reg, p_next;
    logic [SW-1:0] sz_reg, sz_next;
    logic [2:0]    status_reg, status_next;
    logic [15:0]   payload_reg, payload_next;
    logic          mv_reg, mv_next;
    logic [2:0]    ms_reg, ms_next;
    logic [15:0]   mp_reg, mp_next;
    logic [16:0]   mu_reg, mu_next;

    logic [SW-1:0] rd_size;
    logic          rd_used;
    logic [SW-1:0] room_g, room_p, clamped;
    logic [SW:0]   fw_sum;
    logic [GW-1:0] free_g;
    logic          off_misaligned;

    assign rd_size = rd_data_reg[SW-1:0];
    assign rd_used = rd_data_reg[SW];
    assign room_g  = active_reg - SW'(g_reg);
    assign room_p  = active_reg - SW'(p_reg);
    assign fw_sum  = {1'b0, sz_reg} + {1'b0, rd_size};
    assign free_g  = GW'(s_free_offset >> ffha_pkg::OFS_SHIFT) - GW'(1);
    assign off_misaligned = (s_free_offset[ffha_pkg::OFS_SHIFT-1:0] != '0);

    always_comb begin
        if (cfg_reg < 13'd2) begin
            clamped = SW'(2);
        end else if (32'(cfg_reg) > ffha_pkg::ARENA_GRANULES) begin
            clamped = SW'(ffha_pkg::ARENA_GRANULES);
        end else begin
            clamped = SW'(cfg_reg);
        end
    end

    always_comb begin
        sts.req_zero    = (s_request_bytes == '0);
        sts.free_reject = (s_free_offset == '0) || off_misaligned ||
                          (SW'(free_g) >= active_reg);
        sts.sweep_last  = (sweep_reg == '1);
        sts.a_fit       = !rd_used && ({1'b0, rd_size} >= need_reg);
        sts.a_split     = ({1'b0, rd_size} >= need_reg + NW'(2));
        sts.a_last      = (rd_size == '0) || (rd_size >= room_g);
        sts.f_in_use    = rd_used;
        sts.f_last      = (rd_size >= room_g);
        sts.fw_stop     = rd_used || (fw_sum >= {1'b0, room_g});
        sts.g_zero      = (g_reg == '0);
        sts.bk_end      = (rd_size == '0) || (rd_size >= room_p) ||
                          (SW'(p_reg) + rd_size == SW'(g_reg));
        sts.out_free    = !mv_reg || m_ready;
    end

    // Memory address and write selection.
    always_comb begin
        rd_addr = g_reg;
        wr_en   = 1'b0;
        wr_addr = g_reg;
        wr_data = '0;
        unique case (cmd.act)
            ffha_pkg::ACT_FW_RD: rd_addr = GW'(SW'(g_reg) + sz_reg);
            ffha_pkg::ACT_BK_RD: rd_addr = p_reg;
            ffha_pkg::ACT_SWEEP: begin
                wr_en   = 1'b1;
                wr_addr = sweep_reg;
            end
            ffha_pkg::ACT_SEED: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = {1'b0, active_reg};
            end
            ffha_pkg::ACT_A_CHK: begin
                if (sts.a_fit && sts.a_split) begin
                    wr_en   = 1'b1;
                    wr_addr = GW'(NW'(g_reg) + need_reg);
                    wr_data = {1'b0, SW'(NW'(rd_size) - need_reg)};
                end else if (sts.a_fit) begin
                    wr_en   = 1'b1;
                    wr_data = {1'b1, rd_size};
                end
            end
            ffha_pkg::ACT_A_WR2: begin
                wr_en   = 1'b1;
                wr_data = {1'b1, SW'(need_reg)};
            end
            ffha_pkg::ACT_FW_WR: begin
                wr_en   = 1'b1;
                wr_data = {1'b0, sz_reg};
            end
            ffha_pkg::ACT_BK_CHK: begin
                if (sts.bk_end && !rd_used) begin
                    wr_en   = 1'b1;
                    wr_addr = p_reg;
                    wr_data = {1'b0, SW'(fw_sum)};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        cfg_next     = cfg_valid ? cfg_arena_granules : cfg_reg;
        active_next  = active_reg;
        used_next    = used_reg;
        sweep_next   = sweep_reg;
        need_next    = need_reg;
        g_next       = g_reg;
        p_next       = p_reg;
        sz_next      = sz_reg;
        status_next  = status_reg;
        payload_next = payload_reg;
        mv_next      = mv_reg && !m_ready;
        ms_next      = ms_reg;
        mp_next      = mp_reg;
        mu_next      = mu_reg;
        unique case (cmd.act)
            ffha_pkg::ACT_ACCEPT: begin
                need_next    = NW'((18'(s_request_bytes) +
                                    18'(ffha_pkg::GRANULE_BYTES - 1))
                                   >> ffha_pkg::OFS_SHIFT) + NW'(1);
                g_next       = (s_opcode == ffha_pkg::OP_FREE) ? free_g : '0;
                payload_next = '0;
                status_next  = ffha_pkg::STS_OK;
                if (s_opcode == ffha_pkg::OP_ALLOC && sts.req_zero) begin
                    status_next = ffha_pkg::STS_ZERO_SIZE;
                end else if (s_opcode == ffha_pkg::OP_FREE && s_free_offset == '0) begin
                    status_next = ffha_pkg::STS_NULL_FREE;
                end else if (s_opcode == ffha_pkg::OP_FREE && sts.free_reject) begin
                    status_next = ffha_pkg::STS_BAD_FREE;
                end
                if (s_opcode == ffha_pkg::OP_INIT) begin
                    active_next = clamped;
                    sweep_next  = '0;
                    used_next   = '0;
                end
            end
            ffha_pkg::ACT_SWEEP: sweep_next = sweep_reg + GW'(1);
            ffha_pkg::ACT_SEED:  used_next  = '0;
            ffha_pkg::ACT_A_CHK: begin
                if (sts.a_fit) begin
                    used_next    = used_reg + (sts.a_split ? SW'(need_reg) : rd_size);
                    payload_next = 16'((32'(g_reg) + 32'd1) << ffha_pkg::OFS_SHIFT);
                end else if (sts.a_last) begin
                    status_next = ffha_pkg::STS_NO_ROOM;
                end else begin
                    g_next = GW'(SW'(g_reg) + rd_size);
                end
            end
            ffha_pkg::ACT_F_CHK: begin
                if (!rd_used) begin
                    status_next = ffha_pkg::STS_BAD_FREE;
                end else begin
                    sz_next   = rd_size;
                    used_next = used_reg - rd_size;
                end
            end
            ffha_pkg::ACT_FW_CHK: begin
                if (!rd_used) begin
                    sz_next = SW'(fw_sum);
                end
            end
            ffha_pkg::ACT_FW_WR: p_next = '0;
            ffha_pkg::ACT_BK_CHK: begin
                if (!sts.bk_end) begin
                    p_next = GW'(SW'(p_reg) + rd_size);
                end
            end
            ffha_pkg::ACT_RESP: begin
                if (sts.out_free) begin
                    mv_next = 1'b1;
                    ms_next = status_reg;
                    mp_next = payload_reg;
                    mu_next = 17'(32'(used_reg) << ffha_pkg::OFS_SHIFT);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg    <= 13'(ffha_pkg::ARENA_GRANULES);
            active_reg <= SW'(ffha_pkg::ARENA_GRANULES);
            used_reg   <= '0;
            sweep_reg  <= '0;
            mv_reg     <= 1'b0;
        end else begin
            cfg_reg    <= cfg_next;
            active_reg <= active_next;
            used_reg   <= used_next;
            sweep_reg  <= sweep_next;
            mv_reg     <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        need_reg    <= need_next;
        g_reg       <= g_next;
        p_reg       <= p_next;
        sz_reg      <= sz_next;
        status_reg  <= status_next;
        payload_reg <= payload_next;
        ms_reg      <= ms_next;
        mp_reg      <= mp_next;
        mu_reg      <= mu_next;
    end

    assign m_valid          = mv_reg;
    assign m_status         = ms_reg;
    assign m_payload_offset = mp_reg;
    assign m_used_bytes     = mu_reg;

    `FFHA_ASSERT_ALWAYS(a_used_in_arena, used_reg <= active_reg, "used granules exceed arena")
    `FFHA_ASSERT_WHEN(a_walk_in_arena, cmd.act == ffha_pkg::ACT_A_RD, SW'(g_reg) < active_reg, "alloc walk left arena")
    `FFHA_ASSERT_WHEN(a_merge_in_arena, cmd.act == ffha_pkg::ACT_FW_RD, SW'(g_reg) + sz_reg < active_reg, "merge read left arena")

endmodule

// ===== src/ffha_ctrl.sv =====
// Controller state machine of the allocator.
module ffha_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_opcode,
    input  ffha_pkg::ffha_sts_t  sts,
    output ffha_pkg::ffha_cmd_t  cmd
);

    typedef enum logic [13:0] {
        S_SWEEP  = 14'b00000000000001,
        S_SEED   = 14'b00000000000010,
        S_IDLE   = 14'b00000000000100,
        S_A_RD   = 14'b00000000001000,
        S_A_CHK  = 14'b00000000010000,
        S_A_WR2  = 14'b00000000100000,
        S_F_RD   = 14'b00000001000000,
        S_F_CHK  = 14'b00000010000000,
        S_FW_RD  = 14'b00000100000000,
        S_FW_CHK = 14'b00001000000000,
        S_FW_WR  = 14'b00010000000000,
        S_BK_RD  = 14'b00100000000000,
        S_BK_CHK = 14'b01000000000000,
        S_RESP   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   boot_reg, boot_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        boot_next  = boot_reg;
        cmd.act    = ffha_pkg::ACT_NOP;
        unique case (state_reg)
            S_SWEEP: begin
                cmd.act = ffha_pkg::ACT_SWEEP;
                if (sts.sweep_last) begin
                    state_next = S_SEED;
                end
            end
            S_SEED: begin
                cmd.act    = ffha_pkg::ACT_SEED;
                boot_next  = 1'b0;
                state_next = boot_reg ? S_IDLE : S_RESP;
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.act = ffha_pkg::ACT_ACCEPT;
                    priority if (s_opcode == ffha_pkg::OP_ALLOC) begin
                        state_next = sts.req_zero ? S_RESP : S_A_RD;
                    end else if (s_opcode == ffha_pkg::OP_FREE) begin
                        state_next = sts.free_reject ? S_RESP : S_F_RD;
                    end else if (s_opcode == ffha_pkg::OP_INIT) begin
                        state_next = S_SWEEP;
                    end else begin
                        state_next = S_RESP;
                    end
                end
            end
            S_A_RD: begin
                cmd.act    = ffha_pkg::ACT_A_RD;
                state_next = S_A_CHK;
            end
            S_A_CHK: begin
                cmd.act = ffha_pkg::ACT_A_CHK;
                priority if (sts.a_fit && sts.a_split) begin
                    state_next = S_A_WR2;
                end else if (sts.a_fit || sts.a_last) begin
                    state_next = S_RESP;
                end else begin
                    state_next = S_A_RD;
                end
            end
            S_A_WR2: begin
                cmd.act    = ffha_pkg::ACT_A_WR2;
                state_next = S_RESP;
            end
            S_F_RD: begin
                cmd.act    = ffha_pkg::ACT_F_RD;
                state_next = S_F_CHK;
            end
            S_F_CHK: begin
                cmd.act = ffha_pkg::ACT_F_CHK;
                priority if (!sts.f_in_use) begin
                    state_next = S_RESP;
                end else if (sts.f_last) begin
                    state_next = S_FW_WR;
                end else begin
                    state_next = S_FW_RD;
                end
            end
            S_FW_RD: begin
                cmd.act    = ffha_pkg::ACT_FW_RD;
                state_next = S_FW_CHK;
            end
            S_FW_CHK: begin
                cmd.act    = ffha_pkg::ACT_FW_CHK;
                state_next = sts.fw_stop ? S_FW_WR : S_FW_RD;
            end
            S_FW_WR: begin
                cmd.act    = ffha_pkg::ACT_FW_WR;
                state_next = sts.g_zero ? S_RESP : S_BK_RD;
            end
            S_BK_RD: begin
                cmd.act    = ffha_pkg::ACT_BK_RD;
                state_next = S_BK_CHK;
            end
            S_BK_CHK: begin
                cmd.act    = ffha_pkg::ACT_BK_CHK;
                state_next = sts.bk_end ? S_RESP : S_BK_RD;
            end
            S_RESP: begin
                cmd.act = ffha_pkg::ACT_RESP;
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_SWEEP;
            boot_reg  <= 1'b1;
        end else begin
            state_reg <= state_next;
            boot_reg  <= boot_next;
        end
    end

endmodule

// ===== src/first_fit_heap_allocator_core.sv =====
// Top level of the first-fit heap allocator: controller plus datapath.
// The block manages an arena of 16-byte granules as an implicit list of block headers
// kept in a 4096-entry header memory with one read and one write port; one beat in gives
// one result beat out. Every step of a walk issues a header read and then uses the
// registered read data, so the memory port sets the rate. An allocate walks the blocks
// from the first header on and takes one more step when the chosen block is split.
// A free marks the block free, merges the free blocks that follow it, and then walks
// from the first header to fold it into a free predecessor. An initialize runs a clearing
// pass over all 4096 header entries. After reset the same clearing pass runs before the
// first input beat is accepted; configuration writes are taken at any time.
// A finished result waits in an output register, so the next input beat can be taken
// while the result beat is still stalled. The arena size register takes effect at the
// next initialize and is saturated to the range from 2 to 4096 granules.
module first_fit_heap_allocator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_arena_granules,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [16:0] s_request_bytes,
    input  logic [15:0] s_free_offset,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [15:0] m_payload_offset,
    output logic [16:0] m_used_bytes
);

    ffha_pkg::ffha_cmd_t cmd;
    ffha_pkg::ffha_sts_t sts;

    // The configuration register can always take a beat.
    assign cfg_ready = 1'b1;

    ffha_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .sts      (sts),
        .cmd      (cmd)
    );

    ffha_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_arena_granules (cfg_arena_granules),
        .s_opcode           (s_opcode),
        .s_request_bytes    (s_request_bytes),
        .s_free_offset      (s_free_offset),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_payload_offset   (m_payload_offset),
        .m_used_bytes       (m_used_bytes),
        .cmd                (cmd),
        .sts                (sts)
    );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the first-fit heap allocator core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // The opcode field has one code that the block must treat as a no-op.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // Nothing accepted on any channel for this many cycles ends the run. The limit lies
    // well above an initialize and the long receiver hold-off, so this is ample.
    localparam int STALL_LIMIT = 30000;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_CYCLES = 10;

    typedef enum logic [1:0] {
        WK_OP,
        WK_PHASE,
        WK_HOLD
    } work_kind_t;

    // One entry of the driver's work list: an operation beat, a phase change that
    // waits for the block to drain and may write the arena size, or a request for a
    // long receiver hold-off.
    typedef struct {
        work_kind_t  kind;
        logic [1:0]  opcode;
        logic [16:0] request_bytes;
        logic [15:0] free_offset;
        bit          write_cfg;
        logic [12:0] cfg_value;
        int          snd_idle;
        int          rcv_idle;
    } work_t;

    typedef struct {
        logic [2:0]  status;
        logic [15:0] payload_offset;
        logic [16:0] used_bytes;
    } alloc_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [12:0] cfg_arena_granules = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode = '0;
    logic [16:0] s_request_bytes = '0;
    logic [15:0] s_free_offset = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [15:0] m_payload_offset;
    logic [16:0] m_used_bytes;

    first_fit_heap_allocator_core u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_arena_granules (cfg_arena_granules),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_opcode           (s_opcode),
        .s_request_bytes    (s_request_bytes),
        .s_free_offset      (s_free_offset),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_payload_offset   (m_payload_offset),
        .m_used_bytes       (m_used_bytes)
    );

    // ------------------------------------------------------------------------------
    // Shadow heap. It mirrors the header table, the in-use marks, the used granule
    // count, the arena size register and the arena size latched at initialize.
    // ------------------------------------------------------------------------------
    int blk_size[ffha_pkg::ARENA_GRANULES];
    bit blk_busy[ffha_pkg::ARENA_GRANULES];
    int used_gran;
    int arena_reg = ffha_pkg::ARENA_GRANULES;
    int arena_live;
    // Payload offsets of the blocks the shadow heap holds as allocated; the stimulus
    // draws its legal frees from here.
    int live_offsets[$];

    alloc_result_t expected_q[$];
    work_t         work_q[$];

    // Header granule of the block that follows the one at g, or the arena end.
    function automatic int next_header(int g);
        int sz;
        sz = blk_size[g];
        if (sz == 0 || sz >= arena_live - g) return arena_live;
        return g + sz;
    endfunction

    function automatic void heap_reinit();
        for (int i = 0; i < ffha_pkg::ARENA_GRANULES; i++) begin
            blk_size[i] = 0;
            blk_busy[i] = 1'b0;
        end
        // The register is saturated only when it is latched here.
        arena_live = (arena_reg < 2) ? 2 :
                     (arena_reg > ffha_pkg::ARENA_GRANULES) ? ffha_pkg::ARENA_GRANULES :
                     arena_reg;
        blk_size[0] = arena_live;
        used_gran = 0;
        live_offsets.delete();
    endfunction

    function automatic logic [2:0] heap_alloc(int bytes, output logic [15:0] ofs);
        int want;
        ofs = '0;
        if (bytes == 0) return ffha_pkg::STS_ZERO_SIZE;
        want = (bytes + ffha_pkg::GRANULE_BYTES - 1) / ffha_pkg::GRANULE_BYTES + 1;
        for (int g = 0; g < arena_live; g = next_header(g)) begin
            if (!blk_busy[g] && blk_size[g] >= want) begin
                // Split only when the remainder could hold a header and a payload.
                if (blk_size[g] >= want + 2) begin
                    blk_size[g + want] = blk_size[g] - want;
                    blk_busy[g + want] = 1'b0;
                    blk_size[g] = want;
                end
                blk_busy[g] = 1'b1;
                used_gran += blk_size[g];
                ofs = 16'((g + 1) * ffha_pkg::GRANULE_BYTES);
                live_offsets.push_back(int'(ofs));
                return ffha_pkg::STS_OK;
            end
        end
        return ffha_pkg::STS_NO_ROOM;
    endfunction

    function automatic logic [2:0] heap_free(int ofs);
        int g;
        int n;
        int prev;
        bit have_prev;
        int hits[$];
        if (ofs == 0) return ffha_pkg::STS_NULL_FREE;
        if (ofs % ffha_pkg::GRANULE_BYTES != 0) return ffha_pkg::STS_BAD_FREE;
        g = ofs / ffha_pkg::GRANULE_BYTES - 1;
        if (g >= arena_live || !blk_busy[g]) return ffha_pkg::STS_BAD_FREE;
        blk_busy[g] = 1'b0;
        used_gran -= blk_size[g];
        hits = live_offsets.find_first_index(x) with (x == ofs);
        if (hits.size() > 0) live_offsets.delete(hits[0]);
        // Absorb every free block that follows.
        forever begin
            n = next_header(g);
            if (n >= arena_live || blk_busy[n]) break;
            blk_size[g] += blk_size[n];
        end
        // Then fold into a free predecessor, if there is one.
        prev = 0;
        have_prev = 1'b0;
        for (int p = 0; p < arena_live && p != g; p = next_header(p)) begin
            prev = p;
            have_prev = 1'b1;
        end
        if (have_prev && !blk_busy[prev]) blk_size[prev] += blk_size[g];
        return ffha_pkg::STS_OK;
    endfunction

    function automatic alloc_result_t heap_step(logic [1:0] op, logic [16:0] req,
                                                logic [15:0] ofs);
        alloc_result_t r;
        r.status = ffha_pkg::STS_OK;
        r.payload_offset = '0;
        case (op)
            ffha_pkg::OP_ALLOC: r.status = heap_alloc(int'(req), r.payload_offset);
            ffha_pkg::OP_FREE:  r.status = heap_free(int'(ofs));
            ffha_pkg::OP_INIT:  heap_reinit();
            default: begin
            end
        endcase
        r.used_bytes = 17'(used_gran * ffha_pkg::GRANULE_BYTES);
        return r;
    endfunction

    // ------------------------------------------------------------------------------
    // Clock and reset. Reset is released on a falling edge.
    // ------------------------------------------------------------------------------
    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
    end

    // ------------------------------------------------------------------------------
    // Driver. It runs on the falling edge, holds a beat until the monitor has counted
    // its acceptance, and takes its work from work_q. Each signal gets at most one
    // nonblocking assignment per step, so a valid that stays high is never lowered
    // and raised again in the same time step.
    // ------------------------------------------------------------------------------
    int in_sent = 0;
    int in_taken = 0;
    int cfg_sent = 0;
    int cfg_taken = 0;
    int snd_idle = 37;
    int rcv_idle = 64;
    int hold_req = 0;
    int quiet_cnt = 0;

    always @(negedge aclk) begin
        work_t head;
        bit nxt_valid;
        bit nxt_cfg;
        if (aresetn) begin
            if (s_valid && in_taken != in_sent) begin
                // The current operation beat is still waiting for s_ready.
            end else if (cfg_valid && cfg_taken != cfg_sent) begin
                // The register write is still waiting for cfg_ready.
            end else begin
                nxt_valid = 1'b0;
                nxt_cfg = 1'b0;
                if (work_q.size() > 0) begin
                    head = work_q[0];
                    case (head.kind)
                        WK_OP: begin
                            if ($urandom_range(99) >= snd_idle) begin
                                s_opcode <= head.opcode;
                                s_request_bytes <= head.request_bytes;
                                s_free_offset <= head.free_offset;
                                nxt_valid = 1'b1;
                                in_sent++;
                                void'(work_q.pop_front());
                            end
                        end
                        WK_HOLD: begin
                            // The hold-off is counted by the receiver itself; the sender
                            // just keeps going so the block backs up.
                            hold_req <= hold_req + 1;
                            void'(work_q.pop_front());
                        end
                        default: begin
                            // A phase change waits until every result has come back,
                            // then lets the block settle before the register is touched.
                            if (expected_q.size() == 0 && in_taken == in_sent) begin
                                if (quiet_cnt < QUIET_CYCLES) begin
                                    quiet_cnt++;
                                end else begin
                                    quiet_cnt = 0;
                                    snd_idle = head.snd_idle;
                                    rcv_idle <= head.rcv_idle;
                                    if (head.write_cfg) begin
                                        cfg_arena_granules <= head.cfg_value;
                                        nxt_cfg = 1'b1;
                                        cfg_sent++;
                                    end
                                    void'(work_q.pop_front());
                                end
                            end else begin
                                quiet_cnt = 0;
                            end
                        end
                    endcase
                end
                s_valid <= nxt_valid;
                cfg_valid <= nxt_cfg;
            end
        end
    end

    // Receiver. A hold-off request parks m_ready low for a long stretch; otherwise
    // it stalls at random at the current rate.
    int hold_seen = 0;
    int hold_left = 0;

    always @(negedge aclk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    // ------------------------------------------------------------------------------
    // Monitor and checker. Everything is sampled at the rising edge. An accepted
    // operation beat is run through the shadow heap at once, and its result goes to
    // the back of expected_q; each result beat is compared with the front.
    // ------------------------------------------------------------------------------
    int mismatches = 0;
    int results_seen = 0;
    int quiet_edges = 0;
    int status_hits[8];

    always @(posedge aclk) begin
        alloc_result_t want;
        bit moved;
        moved = 1'b0;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                arena_reg = int'(cfg_arena_granules);
                cfg_taken++;
                moved = 1'b1;
            end
            if (s_valid && s_ready) begin
                expected_q.push_back(heap_step(s_opcode, s_request_bytes, s_free_offset));
                in_taken++;
                moved = 1'b1;
            end
            if (m_valid && m_ready) begin
                moved = 1'b1;
                results_seen++;
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"ERROR: result beat with nothing pending: ",
                                  "status %0d ofs %0d used %0d"},
                                 m_status, m_payload_offset, m_used_bytes);
                end else begin
                    want = expected_q.pop_front();
                    status_hits[want.status]++;
                    if (m_status !== want.status ||
                        m_payload_offset !== want.payload_offset ||
                        m_used_bytes !== want.used_bytes) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"ERROR: result %0d: status %0d/%0d ofs %0d/%0d ",
                                      "used %0d/%0d (exp/act)"},
                                     results_seen, want.status, m_status,
                                     want.payload_offset, m_payload_offset,
                                     want.used_bytes, m_used_bytes);
                    end
                end
            end
        end
        // Watchdog: the clearing pass after reset counts as a quiet stretch too.
        quiet_edges = moved ? 0 : quiet_edges + 1;
        if (quiet_edges >= STALL_LIMIT) begin
            $display("ERROR: no beat moved for %0d cycles", STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------------
    // Stimulus. Work is produced a little ahead of the driver, so that legal frees
    // can be drawn from the blocks the shadow heap currently holds.
    // ------------------------------------------------------------------------------
    task automatic push_work(work_t w);
        while (work_q.size() > 3) @(posedge aclk);
        work_q.push_back(w);
    endtask

    task automatic push_op(logic [1:0] op, logic [16:0] req, logic [15:0] ofs);
        work_t w;
        w = '{kind: WK_OP, opcode: op, request_bytes: req, free_offset: ofs,
              write_cfg: 1'b0, cfg_value: '0, snd_idle: 0, rcv_idle: 0};
        push_work(w);
    endtask

    // Drain, optionally write the arena size, switch the idle rates, and start the
    // phase with an initialize so the new size takes effect.
    task automatic start_phase(bit wr, int arena, int snd, int rcv);
        work_t w;
        w = '{kind: WK_PHASE, opcode: ffha_pkg::OP_INIT, request_bytes: '0,
              free_offset: '0, write_cfg: wr, cfg_value: 13'(arena), snd_idle: snd,
              rcv_idle: rcv};
        push_work(w);
        push_op(ffha_pkg::OP_INIT, 17'($urandom), 16'($urandom));
    endtask

    // Mostly allocate/free traffic over live blocks; the rest is malformed frees,
    // null frees, odd sizes, the unused opcode and an occasional re-initialize.
    task automatic random_ops(int count, int max_req);
        int pick;
        logic [15:0] ofs;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 48) begin
                if ($urandom_range(9) == 0)
                    push_op(ffha_pkg::OP_ALLOC, 17'($urandom), 16'($urandom));
                else
                    push_op(ffha_pkg::OP_ALLOC, 17'($urandom_range(max_req, 1)),
                            16'($urandom));
            end else if (pick < 85) begin
                if (live_offsets.size() > 0)
                    ofs = 16'(live_offsets[$urandom_range(live_offsets.size() - 1)]);
                else
                    ofs = 16'($urandom_range(8, 1) * ffha_pkg::GRANULE_BYTES);
                push_op(ffha_pkg::OP_FREE, 17'($urandom), ofs);
            end else if (pick < 93) begin
                push_op(ffha_pkg::OP_FREE, 17'($urandom), 16'($urandom));
            end else if (pick < 96) begin
                push_op(ffha_pkg::OP_FREE, 17'($urandom), '0);
            end else if (pick < 98) begin
                push_op(OP_UNUSED, 17'($urandom), 16'($urandom));
            end else if (pick < 99) begin
                push_op(ffha_pkg::OP_ALLOC, '0, 16'($urandom));
            end else begin
                push_op(ffha_pkg::OP_INIT, 17'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin
        work_t w;
        @(posedge aresetn);

        // Directed: the full reset-size arena, both field extremes and every status.
        start_phase(1'b0, 0, 37, 64);
        push_op(ffha_pkg::OP_ALLOC, '0, '0);                // zero-size request
        push_op(ffha_pkg::OP_ALLOC, 17'd1, '0);             // smallest block, split off
        push_op(ffha_pkg::OP_ALLOC, 17'd16, '0);
        push_op(ffha_pkg::OP_ALLOC, 17'd17, 16'hFFFF);
        push_op(ffha_pkg::OP_ALLOC, 17'd65536, '0);         // larger than the whole arena
        push_op(ffha_pkg::OP_ALLOC, 17'h1FFFF, '0);         // every request bit set
        push_op(ffha_pkg::OP_FREE, '0, '0);                 // null pointer
        push_op(ffha_pkg::OP_FREE, '0, 16'd8);              // misaligned
        push_op(ffha_pkg::OP_FREE, 17'h1FFFF, 16'hFFFF);    // every offset bit set
        push_op(ffha_pkg::OP_FREE, '0, 16'd65520);          // header never allocated
        push_op(OP_UNUSED, 17'h1FFFF, 16'hFFFF);            // unused opcode
        push_op(ffha_pkg::OP_FREE, '0, 16'd32);             // inside the first block, not a header
        push_op(ffha_pkg::OP_FREE, '0, 16'd32);             // the same interior offset again
        push_op(ffha_pkg::OP_FREE, '0, 16'd16);             // frees the first block; its neighbour is in use
        push_op(ffha_pkg::OP_ALLOC, 17'd65519, '0);         // needs all 4096 granules: no room
        push_op(ffha_pkg::OP_ALLOC, 17'd40, '0);
        push_op(ffha_pkg::OP_FREE, '0, 16'd80);             // frees a block between two in-use neighbours
        random_ops(150, 200);

        // Register below the floor: saturates to a two-granule arena.
        start_phase(1'b1, 0, 64, 37);
        push_op(ffha_pkg::OP_ALLOC, 17'd16, '0);
        push_op(ffha_pkg::OP_ALLOC, 17'd1, '0);             // no room left
        push_op(ffha_pkg::OP_FREE, '0, 16'd32);             // inside the allocated block, not a header
        random_ops(40, 24);

        // Register above the ceiling: saturates to the full arena. Half way through
        // the receiver holds off while the sender keeps offering beats.
        start_phase(1'b1, 8191, 0, 0);
        random_ops(70, 300);
        w = '{kind: WK_HOLD, opcode: ffha_pkg::OP_ALLOC, request_bytes: '0,
              free_offset: '0, write_cfg: 1'b0, cfg_value: '0, snd_idle: 0, rcv_idle: 0};
        push_work(w);
        random_ops(80, 300);

        // A small arena that fills up often.
        start_phase(1'b1, 24, 37, 64);
        random_ops(100, 120);

        // The smallest legal setting.
        start_phase(1'b1, 2, 64, 37);
        random_ops(40, 20);

        // Back to the largest legal setting with no idling at all.
        start_phase(1'b1, 4096, 0, 0);
        random_ops(110, 1000);

        while (work_q.size() > 0 || in_taken != in_sent || expected_q.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display({"Checked %0d results: ok %0d, zero-size %0d, no room %0d, ",
                  "bad free %0d, null %0d"},
                 results_seen, status_hits[ffha_pkg::STS_OK],
                 status_hits[ffha_pkg::STS_ZERO_SIZE], status_hits[ffha_pkg::STS_NO_ROOM],
                 status_hits[ffha_pkg::STS_BAD_FREE], status_hits[ffha_pkg::STS_NULL_FREE]);
        $display("Arena sizes 2 through 4096 under three idle mixes, %0d mismatches",
                 mismatches);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/ffha_pkg.sv
src/ffha_datapath.sv
src/ffha_ctrl.sv
src/first_fit_heap_allocator_core.sv
dv/testbench.sv
